// ----- rtl/lirs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lirs_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int MAX_OUT_DEF     = 16;

	// step and phase carry this many integer bits above the fraction
	localparam int STEP_INT_BITS = 5;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// register index, taken from paddr[2]
	localparam logic REG_STEP = 1'b0;

	typedef struct packed {
		logic load;
		logic last;
	} emit_t;

endpackage

`default_nettype wire

// ----- rtl/lirs_interp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lirs_interp
	import lirs_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          mul_en,
	input  wire logic        [FRAC_BITS-1:0]   frac,
	input  wire logic signed [SAMPLE_BITS-1:0] prev,
	input  wire logic signed [SAMPLE_BITS-1:0] cur,
	output logic signed      [SAMPLE_BITS-1:0] result
);

	localparam int DIFF_W = SAMPLE_BITS + 1;
	localparam int PROD_W = DIFF_W + FRAC_BITS + 1;
	localparam int NUM_W  = SAMPLE_BITS + FRAC_BITS + 2;

	logic signed [DIFF_W-1:0]      diff;
	logic signed [FRAC_BITS:0]     frac_s;
	logic signed [PROD_W-1:0]      product_s1;
	logic signed [SAMPLE_BITS-1:0] prev_s1;
	logic signed [NUM_W-1:0]       num;
	logic signed [NUM_W-1:0]       bias;
	logic signed [NUM_W-1:0]       adj;

	assign diff   = DIFF_W'(cur) - DIFF_W'(prev);
	assign frac_s = signed'({1'b0, frac});

	always_ff @(posedge clk) begin
		if (mul_en) begin
			product_s1 <= PROD_W'(diff) * PROD_W'(frac_s);
			prev_s1    <= prev;
		end
	end

	// truncate toward zero: bias negative numerators before the shift
	assign num  = (NUM_W'(prev_s1) <<< FRAC_BITS) + NUM_W'(product_s1);
	assign bias = num[NUM_W-1] ? signed'({{(NUM_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}})
	                           : '0;
	assign adj  = num + bias;
	assign result = adj[FRAC_BITS +: SAMPLE_BITS];

endmodule

`default_nettype wire

// ----- rtl/lirs_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lirs_seq
	import lirs_pkg::*;
#(
	parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
	parameter int FRAC_BITS      = FRAC_BITS_DEF,
	parameter int MAX_OUT_PER_IN = MAX_OUT_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]       sample_in,
	input  wire logic [FRAC_BITS+STEP_INT_BITS-1:0]  step,
	input  wire logic                                out_free,
	output logic                                     mul_en,
	output logic [FRAC_BITS-1:0]                     frac,
	output logic signed [SAMPLE_BITS-1:0]            prev,
	output logic signed [SAMPLE_BITS-1:0]            cur,
	output emit_t                                    emit
);

	localparam int STEP_W = FRAC_BITS + STEP_INT_BITS;
	localparam int PH_W   = STEP_W + 1;
	localparam int CNT_W  = $clog2(MAX_OUT_PER_IN + 1);
	localparam logic [PH_W-1:0] ONE = PH_W'(1) << FRAC_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_ADD  = 2'd2;

	logic [1:0]                    state_q;
	logic                          have_prev_q;
	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic signed [SAMPLE_BITS-1:0] cur_q;
	logic [STEP_W-1:0]             phase_q;
	logic [PH_W-1:0]               ph_w_q;
	logic [PH_W-1:0]               nxt_q;
	logic                          last_q;
	logic [CNT_W-1:0]              cnt_q;

	logic                          accept;
	logic [PH_W-1:0]               phase_ext;
	logic [PH_W-1:0]               phase_ext_sub;
	logic [PH_W-1:0]               nxt_c;
	logic                          last_c;
	logic [PH_W-1:0]               nxt_sub;
	logic [STEP_W-1:0]             fin_ph;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	assign phase_ext     = {1'b0, phase_q};
	assign phase_ext_sub = phase_ext - ONE;
	assign nxt_c         = ph_w_q + PH_W'(step);
	assign last_c        = (nxt_c >= ONE) || (cnt_q == CNT_W'(MAX_OUT_PER_IN - 1));
	assign nxt_sub       = nxt_q - ONE;
	// cap hit with phase still under one period: clamp to zero
	assign fin_ph        = (nxt_q >= ONE) ? nxt_sub[STEP_W-1:0] : '0;

	assign mul_en    = (state_q == ST_MUL);
	assign frac      = ph_w_q[FRAC_BITS-1:0];
	assign prev      = prev_q;
	assign cur       = cur_q;
	assign emit.load = (state_q == ST_ADD) && out_free;
	assign emit.last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			have_prev_q <= 1'b0;
			prev_q      <= '0;
			phase_q     <= '0;
			cnt_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!have_prev_q) begin
							prev_q      <= sample_in;
							have_prev_q <= 1'b1;
						end else if (phase_ext >= ONE) begin
							// no output time in this period: drop one period
							phase_q <= phase_ext_sub[STEP_W-1:0];
							prev_q  <= sample_in;
						end else begin
							cnt_q   <= '0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (out_free) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (last_q) begin
							phase_q <= fin_ph;
							prev_q  <= cur_q;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q  <= sample_in;
			ph_w_q <= phase_ext;
		end
		if (state_q == ST_MUL) begin
			nxt_q  <= nxt_c;
			last_q <= last_c;
		end
		if (state_q == ST_ADD && out_free && !last_q) begin
			ph_w_q <= nxt_q;
		end
	end

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_OUT_PER_IN))
		else $error("output count beyond cap");

	a_phase_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_ADD) |-> ph_w_q < ONE)
		else $error("working phase not under one period");

	a_add_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADD |-> $past(state_q) == ST_MUL || $past(state_q) == ST_ADD)
		else $error("add step without product");

	a_loop_back: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADD && out_free && !last_q) |=> state_q == ST_MUL)
		else $error("run ended before last item");

endmodule

`default_nettype wire

// ----- rtl/linear_interp_resampler_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Linear-interpolation resampler. Each accepted input sample yields zero or
// more interpolated samples between the previous and the current input, the
// final one flagged by last_of_run; the very first sample after reset only
// primes the history. Each result goes through the one shared multiply /
// add-and-round unit as a product step, then a sum and truncation step;
// in_stall stays high from the accept until the item's last result is
// loaded, and a stalled output register holds it high longer. An item
// with no result leaves in_stall low; an item yields MAX_OUT_PER_IN results at most.
// step_ratio sits at byte address 0 (index in paddr[2]), reset to 1.0.
module linear_interp_resampler_unit
	import lirs_pkg::*;
#(
	parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
	parameter int FRAC_BITS      = FRAC_BITS_DEF,
	parameter int MAX_OUT_PER_IN = MAX_OUT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ADDR_W-1:0]             paddr,
	input  wire logic [DATA_W-1:0]             pwdata,
	output logic      [DATA_W-1:0]             prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0]      sample_out,
	output logic                               last_of_run
);

	localparam int STEP_W = FRAC_BITS + STEP_INT_BITS;

	logic [STEP_W-1:0]             step_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                          last_q;
	logic                          out_free;
	logic                          mul_en;
	logic [FRAC_BITS-1:0]          frac;
	logic signed [SAMPLE_BITS-1:0] prev;
	logic signed [SAMPLE_BITS-1:0] cur;
	logic signed [SAMPLE_BITS-1:0] result;
	emit_t                         emit;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_STEP) ? DATA_W'(step_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_W'(1) << FRAC_BITS;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_STEP) begin
			step_q <= pwdata[STEP_W-1:0];
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			sample_out_q <= result;
			last_q       <= emit.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign sample_out  = sample_out_q;
	assign last_of_run = last_q;

	lirs_seq #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.FRAC_BITS      (FRAC_BITS),
		.MAX_OUT_PER_IN (MAX_OUT_PER_IN)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample_in (sample_in),
		.step      (step_q),
		.out_free  (out_free),
		.mul_en    (mul_en),
		.frac      (frac),
		.prev      (prev),
		.cur       (cur),
		.emit      (emit)
	);

	lirs_interp #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_interp (
		.clk    (clk),
		.mul_en (mul_en),
		.frac   (frac),
		.prev   (prev),
		.cur    (cur),
		.result (result)
	);

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import lirs_pkg::*;

	localparam int SW          = SAMPLE_BITS_DEF;
	localparam int FRAC        = FRAC_BITS_DEF;
	localparam int STEP_W      = FRAC + STEP_INT_BITS;
	localparam longint ONE_PERIOD = longint'(1) << FRAC;
	localparam int SETTLE_CYCLES = 2 * MAX_OUT_DEF + 8;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 43;

	localparam logic [ADDR_W-1:0] STEP_ADDR   = {REG_STEP, 2'b00};
	localparam logic [ADDR_W-1:0] UNUSED_ADDR = {~REG_STEP, 2'b00};

	typedef struct {
		logic signed [SW-1:0] value;
		logic                 last;
	} resampled_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_W-1:0]    paddr = '0;
	logic [DATA_W-1:0]    pwdata = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic signed [SW-1:0] sample_in = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic signed [SW-1:0] sample_out;
	logic                 last_of_run;

	logic signed [SW-1:0] pending_samples[$];
	resampled_t           expected_samples[$];

	// predictor state
	logic [STEP_W-1:0]    step_q = STEP_W'(ONE_PERIOD);
	logic [STEP_W-1:0]    phase_q = '0;
	logic signed [SW-1:0] last_sample = '0;
	logic                 primed = 1'b0;

	bit  gaps_on = 1'b1;
	int  in_gap = 0;
	int  out_gap = 0;
	int  err_count = 0;
	int  cycle_count = 0;

	linear_interp_resampler_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.last_of_run(last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// sample feeder: hold the item until it is taken, then advance
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 9) == 0) begin
				in_gap = $urandom_range(0, 11);
				in_valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				in_valid <= 1'b1;
				sample_in <= pending_samples.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (out_gap > 0) begin
			out_gap--;
			out_stall <= 1'b1;
		end else if (gaps_on && $urandom_range(0, 9) == 0) begin
			out_gap = $urandom_range(0, 11);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// interpolation predictor, run on each accepted sample
	always @(posedge clk) begin : predict_blk
		longint cur, prv, ph, nxt, num, res;
		int n;
		resampled_t r;
		if (arst_n && psel && penable && pwrite && pready && paddr[2] == REG_STEP)
			step_q = pwdata[STEP_W-1:0];
		if (arst_n && in_valid && !in_stall) begin
			cur = longint'(sample_in);
			if (!primed) begin
				primed = 1'b1;
			end else begin
				prv = longint'(last_sample);
				ph = longint'(phase_q);
				n = 0;
				while (ph < ONE_PERIOD && n < MAX_OUT_DEF) begin
					// difference taken at full width, truncate toward zero
					num = prv * ONE_PERIOD + ph * (cur - prv);
					res = (num < 0) ? -((-num) >>> FRAC) : (num >>> FRAC);
					nxt = ph + longint'(step_q);
					n++;
					r.value = res[SW-1:0];
					r.last = !(nxt < ONE_PERIOD && n < MAX_OUT_DEF);
					expected_samples.push_back(r);
					ph = nxt;
				end
				// cap hit below one period: saturate phase to zero
				ph = (ph >= ONE_PERIOD) ? ph - ONE_PERIOD : 0;
				phase_q = ph[STEP_W-1:0];
			end
			last_sample = sample_in;
		end
	end

	always @(posedge clk) begin : check_blk
		resampled_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_samples.size() == 0) begin
				if (err_count < 10)
					$display("unexpected result: sample_out %0d last_of_run %0b",
						sample_out, last_of_run);
				err_count++;
			end else begin
				want = expected_samples.pop_front();
				if (sample_out !== want.value || last_of_run !== want.last) begin
					if (err_count < 10)
						$display({"mismatch: sample_out %0d (expected %0d), ",
							"last_of_run %0b (expected %0b)"},
							sample_out, want.value, last_of_run, want.last);
					err_count++;
				end
			end
		end
	end

	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// wait for the block to go idle before touching the register
	task automatic settle();
		while (pending_samples.size() != 0 || in_valid || expected_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic feed(input logic signed [SW-1:0] s);
		pending_samples.push_back(s);
	endtask

	initial begin : stimulus
		logic [DATA_W-1:0] step_val;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unit step at reset: priming, then full-scale swings
		feed(16'sh7fff);
		feed(16'sh8000);
		feed(16'sh7fff);
		feed(16'sh0000);
		feed(-16'sd1);
		settle();

		// half step; odd differences exercise truncation of negatives
		reg_write(STEP_ADDR, 32'h0000_8000);
		reg_write(UNUSED_ADDR, 32'hffff_ffff);
		feed(16'sh8000);
		feed(16'sh7fff);
		feed(16'sh8000);
		feed(16'sd1);
		feed(-16'sd2);
		feed(16'sd3);
		settle();

		// zero step with upper bits set: output cap and phase saturation
		reg_write(STEP_ADDR, 32'hffe0_0000);
		feed(16'sd100);
		feed(-16'sd100);
		settle();

		reg_write(STEP_ADDR, 32'd4096);
		feed(16'sh7fff);
		feed(16'sh8000);
		settle();

		// largest step: deep downsampling
		reg_write(STEP_ADDR, 32'hffff_ffff);
		repeat (5) feed(SW'($urandom));
		settle();

		reg_write(STEP_ADDR, 32'd1048576);
		repeat (3) feed(SW'($urandom));
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 4))
				0: step_val = $urandom_range(4096, 65536);
				1: step_val = $urandom_range(65536, 1048576);
				2: step_val = $urandom_range(4096, 20000);
				3: step_val = $urandom;
				default: step_val = $urandom_range(20000, 140000);
			endcase
			if (p == RANDOM_PHASES - 1) begin
				gaps_on = 1'b0;
				step_val = 32'd65536;
			end
			reg_write(STEP_ADDR, step_val);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				case ($urandom_range(0, 3))
					0: feed($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
					1: feed(SW'($urandom_range(0, 200)) - 16'sd100);
					default: feed(SW'($urandom));
				endcase
			end
			settle();
		end

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
